// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
// No dependencies; every other file but jsu_in_if.sv imports this package.
package jsu_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_DATA     = 3'd0,
		ST_DONE     = 3'd1,
		ST_BADESC   = 3'd2,
		ST_NONASCII = 3'd3,
		ST_BADHEX   = 3'd4,
		ST_LONG     = 3'd5,
		ST_NOQUOTE  = 3'd6,
		ST_UNTERM   = 3'd7
	} status_t;

	// Parser phases
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_STR  = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX0 = 3'd3,
		PH_HEX1 = 3'd4,
		PH_HEX2 = 3'd5,
		PH_HEX3 = 3'd6
	} phase_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_MODE    = 2'd0;
	localparam logic [1:0] CFG_SUBST   = 2'd1;
	localparam logic [1:0] CFG_MAX_LEN = 2'd2;

	// Mode codes; the fourth code acts as strict
	localparam logic [1:0] MODE_STRICT     = 2'd0;
	localparam logic [1:0] MODE_UTF8       = 2'd1;
	localparam logic [1:0] MODE_PERMISSIVE = 2'd2;

	localparam logic [7:0] SUBST_RESET = 8'd63;

	// Configuration seen by the front end
	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  subst;
		logic [15:0] max_len;
	} cfg_t;

	// Results caused by one input byte: data bytes, then an optional terminal result
	typedef struct packed {
		logic [1:0]      ndata;
		logic [2:0][7:0] data;
		logic            has_term;
		status_t         term_status;
		logic [15:0]     term_len;
	} job_t;

endpackage

// ===== rtl/jsu_in_if.sv =====
// Input byte channel: valid/ready handshake with the raw text byte.
// Depends on nothing beyond the language.
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== rtl/jsu_out_if.sv =====
// Result channel: valid/ready handshake with one decoded result.
// Depends on jsu_pkg for the status type.
interface jsu_out_if import jsu_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	status_t     status;
	logic [15:0] string_length;
	logic        last;

	modport source (output valid, output out_byte, output status, output string_length,
		output last, input ready);
	modport sink   (input valid, input out_byte, input status, input string_length,
		input last, output ready);
endinterface

// ===== rtl/jsu_front.sv =====
// Front end: parser state machine, escape and hex decode, UTF-8 encode, length check.
// Produces at most one job per input transfer. Depends on jsu_pkg and jsu_in_if.
module jsu_front import jsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    byte_ch,
	input  cfg_t      cfg,
	input  logic      queue_full,
	output logic      push,
	output job_t      push_job
);

	phase_t      phase_q, phase_d;
	logic [15:0] hex_q, hex_d;
	logic [15:0] len_q, len_d;

	logic        take;
	logic        do_deliver;
	logic        is_cp;
	logic [15:0] v16;
	logic [7:0]  esc_byte;
	logic        esc_ok;
	logic        hex_ok;
	logic [3:0]  hex_nib;
	logic [15:0] hex_new;
	logic [1:0]  k;
	logic [2:0][7:0] cand;
	logic        nonascii;
	logic        limit_on;
	logic [16:0] room;
	logic        fits;
	logic [1:0]  nd;
	logic [16:0] len_sum;

	assign byte_ch.ready = !queue_full;
	assign take = byte_ch.valid && byte_ch.ready;

	// Escape letter decode
	always_comb begin
		esc_ok = 1'b1;
		esc_byte = 8'h00;
		case (byte_ch.in_byte)
			"t": esc_byte = 8'h09;
			"n": esc_byte = 8'h0a;
			"r": esc_byte = 8'h0d;
			"f": esc_byte = 8'h0c;
			"b": esc_byte = 8'h08;
			"/": esc_byte = "/";
			"\\": esc_byte = "\\";
			"\"": esc_byte = "\"";
			default: esc_ok = 1'b0;
		endcase
	end

	// Hex digit decode
	always_comb begin
		hex_ok = 1'b1;
		hex_nib = 4'h0;
		if (byte_ch.in_byte >= "0" && byte_ch.in_byte <= "9") begin
			hex_nib = 4'(byte_ch.in_byte - "0");
		end else if (byte_ch.in_byte >= "a" && byte_ch.in_byte <= "f") begin
			hex_nib = 4'(byte_ch.in_byte - "a" + 8'd10);
		end else if (byte_ch.in_byte >= "A" && byte_ch.in_byte <= "F") begin
			hex_nib = 4'(byte_ch.in_byte - "A" + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end
	end
	assign hex_new = {hex_q[11:0], hex_nib};

	// Next phase and job classification
	always_comb begin
		phase_d = phase_q;
		hex_d = hex_q;
		do_deliver = 1'b0;
		is_cp = 1'b0;
		v16 = {8'h00, byte_ch.in_byte};
		push_job = '0;
		push_job.term_status = ST_DATA;
		if (byte_ch.end_of_input) begin
			push_job.has_term = 1'b1;
			push_job.term_status = (phase_q == PH_IDLE) ? ST_NOQUOTE : ST_UNTERM;
			phase_d = PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (byte_ch.in_byte == "\"") begin
						phase_d = PH_STR;
					end else if (byte_ch.in_byte != " " && byte_ch.in_byte != 8'h09 &&
							byte_ch.in_byte != 8'h0a && byte_ch.in_byte != 8'h0d) begin
						push_job.has_term = 1'b1;
						push_job.term_status = ST_NOQUOTE;
					end
				end
				PH_STR: begin
					if (byte_ch.in_byte == "\"") begin
						push_job.has_term = 1'b1;
						push_job.term_status = ST_DONE;
						push_job.term_len = len_q;
						phase_d = PH_IDLE;
					end else if (byte_ch.in_byte == "\\") begin
						phase_d = PH_ESC;
					end else begin
						do_deliver = 1'b1;
					end
				end
				PH_ESC: begin
					if (byte_ch.in_byte == "u") begin
						hex_d = '0;
						phase_d = PH_HEX0;
					end else if (!esc_ok) begin
						push_job.has_term = 1'b1;
						push_job.term_status = ST_BADESC;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_STR;
						do_deliver = 1'b1;
						v16 = {8'h00, esc_byte};
					end
				end
				PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
					if (!hex_ok) begin
						push_job.has_term = 1'b1;
						push_job.term_status = ST_BADHEX;
						phase_d = PH_IDLE;
					end else begin
						hex_d = hex_new;
						case (phase_q)
							PH_HEX0: phase_d = PH_HEX1;
							PH_HEX1: phase_d = PH_HEX2;
							PH_HEX2: phase_d = PH_HEX3;
							default: begin
								phase_d = PH_STR;
								do_deliver = 1'b1;
								is_cp = 1'b1;
								v16 = hex_new;
							end
						endcase
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end

		// Mode-dependent byte candidates
		k = 2'd1;
		cand = '0;
		nonascii = 1'b0;
		if (cfg.mode == MODE_UTF8) begin
			if (!is_cp || v16 < 16'h0080) begin
				cand[0] = v16[7:0];
			end else if (v16 < 16'h0800) begin
				k = 2'd2;
				cand[0] = 8'hc0 | {3'b000, v16[10:6]};
				cand[1] = 8'h80 | {2'b00, v16[5:0]};
			end else begin
				k = 2'd3;
				cand[0] = 8'he0 | {4'h0, v16[15:12]};
				cand[1] = 8'h80 | {2'b00, v16[11:6]};
				cand[2] = 8'h80 | {2'b00, v16[5:0]};
			end
		end else if (cfg.mode == MODE_PERMISSIVE) begin
			cand[0] = (v16 < 16'd32 || v16 >= 16'd127) ? cfg.subst : v16[7:0];
		end else begin
			nonascii = (v16 >= 16'd127);
			cand[0] = v16[7:0];
		end

		// Length limit: emit what fits, then flag too long
		limit_on = (cfg.max_len != 16'h0000);
		room = {1'b0, cfg.max_len} - {1'b0, len_q};
		fits = !limit_on || (!room[16] && room >= {15'h0000, k});
		nd = fits ? k : (room[16] ? 2'd0 : room[1:0]);
		len_sum = {1'b0, len_q} + {15'h0000, nd};
		len_d = len_q;

		if (do_deliver) begin
			if (nonascii) begin
				push_job.has_term = 1'b1;
				push_job.term_status = ST_NONASCII;
				phase_d = PH_IDLE;
			end else begin
				push_job.ndata = nd;
				push_job.data = cand;
				len_d = len_sum[16] ? 16'hffff : len_sum[15:0];
				if (!fits) begin
					push_job.has_term = 1'b1;
					push_job.term_status = ST_LONG;
					phase_d = PH_IDLE;
				end
			end
		end
		// Opening quote starts a fresh count
		if (!byte_ch.end_of_input && phase_q == PH_IDLE && byte_ch.in_byte == "\"") begin
			len_d = '0;
		end
	end

	assign push = take && (push_job.has_term || push_job.ndata != 2'd0);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_q <= '0;
			len_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			hex_q <= hex_d;
			len_q <= len_d;
		end
	end

endmodule

// ===== rtl/jsu_queue.sv =====
// Job queue between front and back end; registered storage, one push and one pop.
// Depends on jsu_pkg for the job type.
module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head_job,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head_job = mem_q[rd_ptr_q];

	// Storage write
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: walks the head job and presents its results one per transfer.
// Depends on jsu_pkg and jsu_out_if.
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head_job,
	input  logic       empty,
	output logic       pop,
	jsu_out_if.source  result_ch
);

	logic [1:0] idx_q;
	logic [2:0] total;
	logic       is_data;
	logic       is_last;
	logic       xfer;

	assign total   = {1'b0, head_job.ndata} + {2'b00, head_job.has_term};
	assign is_data = (idx_q < head_job.ndata);
	assign is_last = (({1'b0, idx_q} + 3'd1) == total);

	// Result payload for the current position
	always_comb begin
		result_ch.out_byte = 8'h00;
		result_ch.status = head_job.term_status;
		result_ch.string_length = head_job.term_len;
		if (is_data) begin
			result_ch.status = ST_DATA;
			result_ch.string_length = '0;
			case (idx_q)
				2'd0: result_ch.out_byte = head_job.data[0];
				2'd1: result_ch.out_byte = head_job.data[1];
				2'd2: result_ch.out_byte = head_job.data[2];
				default: result_ch.out_byte = 8'h00;
			endcase
		end
	end

	assign result_ch.valid = !empty;
	assign result_ch.last = is_last;
	assign xfer = result_ch.valid && result_ch.ready;
	assign pop = xfer && is_last;

	// Position within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (xfer) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ===== rtl/json_string_unescape_core.sv =====
// JSON string unescaper, top level: configuration registers, front end, job queue,
// back end and checks. Depends on jsu_pkg, jsu_in_if, jsu_out_if and the jsu_ modules.
//
// Usage:
//   byte_ch (sink) takes one text byte per transfer, or an end-of-input marker.
//   result_ch (source) gives decoded bytes (status data), then a completion
//   result carrying the string length, or an error result; last marks the
//   final result caused by one input byte. A byte that causes nothing
//   (white space, opening quote, backslash, hex digits) gives no result.
//   cfg_we/cfg_index/cfg_data write mode, substitute byte and length limit;
//   writes must be made only while the block is idle; the block itself does not enforce it.
// Timing:
//   Results of a byte are registered in the job queue before they appear on the
//   result port. A byte is taken every cycle while the job queue has room
//   (QUEUE_DEPTH jobs). The result port moves one result per cycle while the receiver
//   is ready, so a \u escape that encodes to 3 bytes holds the port for three results;
//   sustained rate is one byte per cycle when results average at most one per byte.
// Reset:
//   Parser idle, counters zero, mode strict, substitute 63, no length limit,
//   queue empty.
// Stall:
//   A stalled receiver holds the current result; the queue fills and then
//   byte_ch.ready drops until a job is drained.
module json_string_unescape_core import jsu_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	jsu_in_if.sink      byte_ch,
	jsu_out_if.source   result_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	logic push, full, pop, empty;
	job_t push_job, head_job;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_STRICT;
			cfg_q.subst <= SUBST_RESET;
			cfg_q.max_len <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:    cfg_q.mode <= cfg_data[1:0];
				CFG_SUBST:   cfg_q.subst <= cfg_data[7:0];
				CFG_MAX_LEN: cfg_q.max_len <= cfg_data;
				default: ;
			endcase
		end
	end

	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (byte_ch),
		.cfg        (cfg_q),
		.queue_full (full),
		.push       (push),
		.push_job   (push_job)
	);

	jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (empty)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.empty     (empty),
		.pop       (pop),
		.result_ch (result_ch)
	);

	// Front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into full queue");

	// A terminal result always closes the results of its byte
	a_term_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.status != ST_DATA |-> result_ch.last)
		else $error("terminal result not marked last");

	// Length only on completion, byte only on data
	a_field_usage: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |->
			(result_ch.status == ST_DONE || result_ch.string_length == 16'h0000) &&
			(result_ch.status == ST_DATA || result_ch.out_byte == 8'h00))
		else $error("result field set outside its status");

endmodule

// ===== tb/jsu_unescape_checker.sv =====
// Checker for the JSON string unescaper: predicts the results of every byte transfer
// and compares them in order with the result transfers. Depends on jsu_pkg.
module jsu_unescape_checker import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_eoi,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  status_t     out_status,
	input  logic [15:0] out_len,
	input  logic        out_last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          decoded_pending,
	output int          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] QUOTE_CHAR     = 8'h22;
	localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;

	typedef struct {
		logic [7:0]  data;
		status_t     status;
		logic [15:0] len;
		logic        last;
	} decoded_t;

	decoded_t decoded_q[$];

	// shadow configuration
	logic [1:0]  mode_r  = MODE_STRICT;
	logic [7:0]  subst_r = SUBST_RESET;
	logic [15:0] limit_r = '0;

	// shadow parser state
	phase_t      phase_r      = PH_IDLE;
	logic [15:0] code_point_r = '0;
	logic [15:0] count_r      = '0;

	int fail_tally = 0;
	int backlog    = 0;

	assign mismatches      = fail_tally;
	assign decoded_pending = backlog;

	function automatic void add_decoded(logic [7:0] b, status_t st, logic [15:0] len);
		decoded_t d;
		d.data   = b;
		d.status = st;
		d.len    = len;
		d.last   = 1'b0;
		decoded_q.insert(decoded_q.size(), d);
	endfunction

	// one output byte, or the length error once the limit is reached
	function automatic bit emit_byte(logic [7:0] b);
		if (limit_r != 0 && count_r >= limit_r) begin
			add_decoded('0, ST_LONG, '0);
			phase_r = PH_IDLE;
			return 1'b0;
		end
		add_decoded(b, ST_DATA, '0);
		if (count_r != 16'hFFFF)
			count_r++;
		return 1'b1;
	endfunction

	// decoded value to output bytes according to the mode
	function automatic void deliver_value(logic [15:0] v, bit is_cp);
		case (mode_r)
			MODE_UTF8: begin
				if (!is_cp || v < 16'h80) begin
					void'(emit_byte(v[7:0]));
				end else if (v < 16'h800) begin
					if (emit_byte(8'(v >> 6) | 8'hC0))
						void'(emit_byte(8'(v & 16'h3F) | 8'h80));
				end else begin
					if (emit_byte(8'(v >> 12) | 8'hE0))
						if (emit_byte(8'((v >> 6) & 16'h3F) | 8'h80))
							void'(emit_byte(8'(v & 16'h3F) | 8'h80));
				end
			end
			MODE_PERMISSIVE: begin
				if (v < 32 || v >= 127)
					void'(emit_byte(subst_r));
				else
					void'(emit_byte(v[7:0]));
			end
			default: begin
				// strict, and the unused fourth code
				if (v >= 127) begin
					add_decoded('0, ST_NONASCII, '0);
					phase_r = PH_IDLE;
				end else begin
					void'(emit_byte(v[7:0]));
				end
			end
		endcase
	endfunction

	function automatic int nibble_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	// parser step for one accepted byte; marks the final result of the step
	function automatic void unescape_step(logic [7:0] c, logic eoi);
		int          first;
		int          h;
		logic [7:0]  d;
		bit          ok;
		first = decoded_q.size();
		if (eoi) begin
			add_decoded('0, (phase_r == PH_IDLE) ? ST_NOQUOTE : ST_UNTERM, '0);
			phase_r = PH_IDLE;
		end else begin
			case (phase_r)
				PH_IDLE: begin
					if (c == QUOTE_CHAR) begin
						phase_r = PH_STR;
						count_r = '0;
					end else if (!(c inside {8'h20, 8'h09, 8'h0A, 8'h0D})) begin
						add_decoded('0, ST_NOQUOTE, '0);
					end
				end
				PH_STR: begin
					if (c == QUOTE_CHAR) begin
						add_decoded('0, ST_DONE, count_r);
						phase_r = PH_IDLE;
					end else if (c == BACKSLASH_CHAR) begin
						phase_r = PH_ESC;
					end else begin
						deliver_value({8'h00, c}, 1'b0);
					end
				end
				PH_ESC: begin
					ok = 1'b1;
					d  = '0;
					case (c)
						"t":            d = 8'h09;
						"n":            d = 8'h0A;
						"r":            d = 8'h0D;
						"f":            d = 8'h0C;
						"b":            d = 8'h08;
						"/":            d = "/";
						BACKSLASH_CHAR: d = BACKSLASH_CHAR;
						QUOTE_CHAR:     d = QUOTE_CHAR;
						default:        ok = 1'b0;
					endcase
					if (c == "u") begin
						code_point_r = '0;
						phase_r      = PH_HEX0;
					end else if (!ok) begin
						add_decoded('0, ST_BADESC, '0);
						phase_r = PH_IDLE;
					end else begin
						phase_r = PH_STR;
						deliver_value({8'h00, d}, 1'b0);
					end
				end
				default: begin
					h = nibble_of(c);
					if (h < 0) begin
						add_decoded('0, ST_BADHEX, '0);
						phase_r = PH_IDLE;
					end else begin
						code_point_r = {code_point_r[11:0], h[3:0]};
						if (phase_r == PH_HEX3) begin
							phase_r = PH_STR;
							deliver_value(code_point_r, 1'b1);
						end else begin
							phase_r = phase_t'(phase_r + 3'd1);
						end
					end
				end
			endcase
		end
		if (decoded_q.size() > first)
			decoded_q[decoded_q.size() - 1].last = 1'b1;
	endfunction

	// register writes, byte transfers and result transfers, in that order
	always @(posedge clk or negedge arst_n) begin : track
		decoded_t want;
		if (!arst_n) begin
			mode_r       = MODE_STRICT;
			subst_r      = SUBST_RESET;
			limit_r      = '0;
			phase_r      = PH_IDLE;
			code_point_r = '0;
			count_r      = '0;
			decoded_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:    mode_r  = cfg_data[1:0];
					CFG_SUBST:   subst_r = cfg_data[7:0];
					CFG_MAX_LEN: limit_r = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				unescape_step(in_byte, in_eoi);
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$error("result transfer with none predicted: status %0d byte %0d",
						out_status, out_byte);
					fail_tally++;
				end else begin
					want = decoded_q.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %0d, got %0d", want.data, out_byte);
						fail_tally++;
					end
					if (out_status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_status);
						fail_tally++;
					end
					if (out_len !== want.len) begin
						$error("string_length: expected %0d, got %0d", want.len, out_len);
						fail_tally++;
					end
					if (out_last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_last);
						fail_tally++;
					end
				end
			end
		end
		backlog = decoded_q.size();
	end

endmodule

// ===== tb/json_string_unescape_core_tb.sv =====
// Testbench top for json_string_unescape_core: clock, reset, register writes, byte
// stimulus and result back-pressure. Depends on jsu_pkg, the channel interfaces and the checker.
module json_string_unescape_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import jsu_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int LONG_HOLD      = 64;

	// fourth mode code, decoded as strict
	localparam logic [1:0] MODE_STRICT_ALIAS = 2'd3;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int mismatches;
	int backlog;
	int items_sent = 0;
	bit quiet      = 1'b0;
	bit hold_long  = 1'b0;

	jsu_in_if  byte_ch ();
	jsu_out_if result_ch ();

	always #10 clk = ~clk;

	json_string_unescape_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	jsu_unescape_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (byte_ch.valid),
		.in_ready        (byte_ch.ready),
		.in_byte         (byte_ch.in_byte),
		.in_eoi          (byte_ch.end_of_input),
		.out_valid       (result_ch.valid),
		.out_ready       (result_ch.ready),
		.out_byte        (result_ch.out_byte),
		.out_status      (result_ch.status),
		.out_len         (result_ch.string_length),
		.out_last        (result_ch.last),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.decoded_pending (backlog),
		.mismatches      (mismatches)
	);

	// offer one byte, with an occasional gap first, and wait for its transfer
	task automatic send_item(logic [7:0] b, logic eoi);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		byte_ch.valid        <= 1'b1;
		byte_ch.in_byte      <= b;
		byte_ch.end_of_input <= eoi;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 10)
			return 8'h30 + n;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	task automatic send_code_point(logic [15:0] cp);
		send_item(CH_BSLASH, 1'b0);
		send_item("u", 1'b0);
		for (int k = 3; k >= 0; k--)
			send_item(hex_char(cp[k*4 +: 4]), 1'b0);
	endtask

	// well-formed string with random content; now and then cut off by end of input
	task automatic send_random_string();
		logic [7:0]  c;
		logic [15:0] cp;
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 3))
				0: c = 8'h20;
				1: c = 8'h09;
				2: c = 8'h0D;
				default: c = 8'h0A;
			endcase
			send_item(c, 1'b0);
		end
		send_item(CH_QUOTE, 1'b0);
		repeat ($urandom_range(0, 7)) begin
			case ($urandom_range(0, 4))
				0: begin
					c = 8'($urandom_range(8'h20, 8'h7E));
					if (c == CH_QUOTE || c == CH_BSLASH)
						c = "a";
					send_item(c, 1'b0);
				end
				1: begin
					c = 8'($urandom_range(0, 255));
					if (c == CH_QUOTE)
						c = 8'hFF;
					else if (c == CH_BSLASH)
						c = 8'h00;
					send_item(c, 1'b0);
				end
				2: begin
					case ($urandom_range(0, 7))
						0: c = "t";
						1: c = "n";
						2: c = "r";
						3: c = "f";
						4: c = "b";
						5: c = "/";
						6: c = CH_BSLASH;
						default: c = CH_QUOTE;
					endcase
					send_item(CH_BSLASH, 1'b0);
					send_item(c, 1'b0);
				end
				default: begin
					case ($urandom_range(0, 4))
						0: cp = 16'($urandom_range(0, 16'h7F));
						1: cp = 16'($urandom_range(16'h80, 16'h7FF));
						2: cp = 16'($urandom_range(16'h800, 16'hFFFF));
						3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
						default: begin
							case ($urandom_range(0, 5))
								0: cp = 16'h0000;
								1: cp = 16'h007F;
								2: cp = 16'h0080;
								3: cp = 16'h07FF;
								4: cp = 16'h0800;
								default: cp = 16'hFFFF;
							endcase
						end
					endcase
					send_code_point(cp);
				end
			endcase
		end
		if ($urandom_range(0, 9) == 0)
			send_item(8'($urandom_range(0, 255)), 1'b1);
		else
			send_item(CH_QUOTE, 1'b0);
	endtask

	// noise and broken sequences
	task automatic send_broken();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0: send_item(8'($urandom_range(0, 255)), 1'b0);
			1: send_item(8'($urandom_range(0, 255)), 1'b1);
			2: begin
				c = 8'($urandom_range(0, 255));
				if (c inside {"t", "n", "r", "f", "b", "/", "u", CH_BSLASH, CH_QUOTE})
					c = "q";
				send_item(CH_QUOTE, 1'b0);
				send_item(CH_BSLASH, 1'b0);
				send_item(c, 1'b0);
			end
			3: begin
				send_item(CH_QUOTE, 1'b0);
				send_item(CH_BSLASH, 1'b0);
				send_item("u", 1'b0);
				repeat ($urandom_range(0, 3))
					send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
				if ($urandom_range(0, 3) == 0) begin
					send_item(8'($urandom_range(0, 255)), 1'b1);
				end else begin
					c = 8'($urandom_range(0, 255));
					if (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]})
						c = "g";
					send_item(c, 1'b0);
				end
			end
			default: begin
				send_item(CH_QUOTE, 1'b0);
				repeat ($urandom_range(0, 3))
					send_item("z", 1'b0);
				send_item(CH_BSLASH, 1'b0);
				send_item(8'($urandom_range(0, 255)), 1'b1);
			end
		endcase
	endtask

	// wait until every predicted result has arrived and the block has gone quiet
	task automatic settle();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one setting, then mostly well-formed strings, closed by end of input
	task automatic run_phase(logic [1:0] m, logic [7:0] s, logic [15:0] lim, int count);
		int target;
		write_reg(CFG_MODE, {14'($urandom), m});
		write_reg(CFG_SUBST, {8'($urandom), s});
		write_reg(CFG_MAX_LEN, lim);
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 4) != 0)
				send_random_string();
			else
				send_broken();
		end
		send_item(8'($urandom_range(0, 255)), 1'b1);
		settle();
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		forever begin
			if (hold_long) begin
				result_ch.ready <= 1'b0;
				hold_long = 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("json_string_unescape_core_tb failed");
		$finish;
	end

	// stimulus and verdict
	initial begin
		byte_ch.valid        <= 1'b0;
		byte_ch.in_byte      <= '0;
		byte_ch.end_of_input <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= '0;
		cfg_data             <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: white space skipped, control byte passed in strict,
		// code point 127 rejected, empty string, bad leading byte, end of input while idle,
		// bad escape, bad hex digit, end of input inside a string
		send_item(8'h20, 1'b0);
		send_item(8'h09, 1'b0);
		send_item(8'h0D, 1'b0);
		send_item(8'h0A, 1'b0);
		send_item(CH_QUOTE, 1'b0);
		send_item(8'h00, 1'b0);
		send_text("\\u007F");
		send_text("\"\"");
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		send_text("\"\\q");
		send_text("\"\\ug");
		send_item(CH_QUOTE, 1'b0);
		send_item(8'hFF, 1'b1);
		settle();

		// random phases over several settings; the first one fills the block
		hold_long = 1'b1;
		run_phase(MODE_UTF8, SUBST_RESET, 16'd0, 10);
		run_phase(MODE_PERMISSIVE, 8'h00, 16'd0, 8);
		run_phase(MODE_PERMISSIVE, 8'hFF, 16'd5, 8);
		run_phase(MODE_STRICT_ALIAS, 8'hA5, 16'd0, 6);
		run_phase(MODE_UTF8, 8'h2A, 16'd1, 6);
		run_phase(MODE_UTF8, SUBST_RESET, 16'hFFFF, 6);
		run_phase(MODE_STRICT, SUBST_RESET, 16'd3, 6);

		// closing stretch without idling on either side
		quiet = 1'b1;
		run_phase(MODE_UTF8, 8'($urandom), 16'($urandom_range(2, 8)), 10);

		if (mismatches == 0 && backlog == 0)
			$display("json_string_unescape_core_tb passed");
		else
			$display("json_string_unescape_core_tb failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_core.sv
tb/jsu_unescape_checker.sv
tb/json_string_unescape_core_tb.sv
